### rtl/assert_macros.svh
// assertion macros used by the scan engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication, checked outside reset
`define SFOV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked outside reset
`define SFOV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

### rtl/sfov_pkg.sv
// types, constants and helpers of the field-of-view unit
`default_nettype none
package sfov_pkg;

  localparam int GRID_SIDE_MAX = 64;
  localparam int RADIUS_MAX    = 31;
  localparam int COORD_W       = $clog2(GRID_SIDE_MAX);
  localparam int ADDR_W        = 2 * COORD_W;
  localparam int CELLS         = GRID_SIDE_MAX * GRID_SIDE_MAX;
  localparam int MAP_W         = 7;
  localparam int RAD_W         = 5;
  localparam int STACK_DEPTH   = RADIUS_MAX + 1;
  localparam int STACK_IDX_W   = $clog2(STACK_DEPTH);
  localparam int DEPTH_W       = STACK_IDX_W + 1;
  localparam int ROW_W         = $clog2(RADIUS_MAX + 2);
  localparam int DX_W          = ROW_W + 2;
  localparam int POS_W         = COORD_W + 2;
  localparam int NUM_W         = ROW_W + 3;
  localparam int DEN_W         = ROW_W + 1;
  localparam int PROD_W        = NUM_W + DEN_W + 1;

  // bit layout of one cell entry
  localparam int CELL_W    = 3;
  localparam int CELL_VIS  = 0;
  localparam int CELL_EXP  = 1;
  localparam int CELL_OPAC = 2;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_FOV   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } sfov_op_e;

  typedef enum logic [2:0] {
    T_INIT, T_IDLE, T_WRITE, T_READ, T_START, T_SCAN, T_RESP
  } sfov_top_e;

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_ORIGIN, S_OCT, S_STEP, S_CELL, S_DONE
  } sfov_scan_e;

  typedef struct packed {
    logic [ROW_W-1:0]        row;
    logic signed [DX_W-1:0]  dx;
    logic signed [NUM_W-1:0] sn;
    logic [DEN_W-1:0]        sd;
    logic signed [NUM_W-1:0] en;
    logic [DEN_W-1:0]        ed;
    logic signed [NUM_W-1:0] nn;
    logic [DEN_W-1:0]        nd;
    logic                    blocked;
  } sfov_frame_t;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] wmask;
    logic [CELL_W-1:0] wdata;
  } sfov_mem_req_t;

  typedef struct packed {
    logic [COORD_W-1:0] ox;
    logic [COORD_W-1:0] oy;
    logic [RAD_W-1:0]   radius;
    logic [MAP_W-1:0]   w_eff;
    logic [MAP_W-1:0]   h_eff;
  } sfov_cmd_t;

  // octant transforms: px uses m0, m1 and py uses m2, m3
  localparam logic signed [1:0] OCT_M [8][4] = '{
    '{ 2'sd1,  2'sd0,  2'sd0,  2'sd1}, '{ 2'sd0,  2'sd1,  2'sd1,  2'sd0},
    '{ 2'sd0, -2'sd1,  2'sd1,  2'sd0}, '{-2'sd1,  2'sd0,  2'sd0,  2'sd1},
    '{-2'sd1,  2'sd0,  2'sd0, -2'sd1}, '{ 2'sd0, -2'sd1, -2'sd1,  2'sd0},
    '{ 2'sd0,  2'sd1, -2'sd1,  2'sd0}, '{ 2'sd1,  2'sd0,  2'sd0, -2'sd1}
  };

  function automatic logic signed [DX_W-1:0] unit_mul(input logic signed [1:0] m,
                                                      input logic signed [DX_W-1:0] v);
    logic signed [DX_W-1:0] r;
    r = '0;
    if (m == 2'sd1) r = v;
    else if (m == -2'sd1) r = -v;
    return r;
  endfunction

  // a/b < c/d with positive denominators
  function automatic logic slope_less(input logic signed [NUM_W-1:0] a,
                                      input logic [DEN_W-1:0] b,
                                      input logic signed [NUM_W-1:0] c,
                                      input logic [DEN_W-1:0] d);
    logic signed [PROD_W-1:0] p;
    logic signed [PROD_W-1:0] q;
    p = a * $signed({1'b0, d});
    q = c * $signed({1'b0, b});
    return p < q;
  endfunction

  function automatic logic [MAP_W-1:0] clamp_map(input logic [MAP_W-1:0] v);
    return (v > MAP_W'(GRID_SIDE_MAX)) ? MAP_W'(GRID_SIDE_MAX) : v;
  endfunction

endpackage
`default_nettype wire

### rtl/shadowcast_field_of_view_unit.sv
// top level of the field-of-view unit: item control, map registers and cell memory
// field of view: a sweep that clears the visible bit of every cell, then the steps of the scan engine,
// with a cell state for each scanned cell, all through the single port of the cell memory
// one item at a time; a finished result may wait in the output register while the next is taken
// after reset a clearing pass zeroes every cell of the cell memory; no item is taken meanwhile
// map registers reset to 64 and may be written at any time
`default_nettype none
module shadowcast_field_of_view_unit
  import sfov_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // cell_x[5:0], cell_y[11:6], wall[12], radius[17:13]
  input  wire logic [1:0]  s_axis_tuser,  // opcode[1:0]
  // result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // is_visible[0], is_explored[1], is_wall[2]
  output logic [1:0]       m_axis_tuser,  // op_echo[1:0]
  // map registers
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  sfov_top_e state_q, state_d;

  // accepted item
  logic [1:0]         op_q;
  logic [COORD_W-1:0] x_q, y_q;
  logic               wall_q;
  logic [RAD_W-1:0]   rad_q;

  logic [MAP_W-1:0]   width_q, height_q;
  logic [ADDR_W-1:0]  init_q;

  logic               out_valid_q;
  logic [1:0]         out_op_q;
  logic [CELL_W-1:0]  out_bits_q;

  logic               in_acc, slot_free, scan_done, cfg_wr;
  sfov_cmd_t          scan_cmd;
  sfov_mem_req_t      scan_req, mem_req;
  logic [CELL_W-1:0]  mem_rdata;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign slot_free = !out_valid_q || m_axis_tready;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;

  // register index sits at paddr[2]
  assign prdata = paddr[2] ? {{(32-MAP_W){1'b0}}, height_q} : {{(32-MAP_W){1'b0}}, width_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= MAP_W'(64);
      height_q <= MAP_W'(64);
    end else if (cfg_wr) begin
      if (paddr[2]) height_q <= pwdata[MAP_W-1:0];
      else          width_q  <= pwdata[MAP_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_INIT: if (init_q == '1) state_d = T_IDLE;
      T_IDLE: begin
        if (in_acc) begin
          unique case (sfov_op_e'(s_axis_tuser))
            OP_WRITE: state_d = T_WRITE;
            OP_FOV:   state_d = T_START;
            OP_READ:  state_d = T_READ;
            OP_NONE:  state_d = T_RESP;
            default:  state_d = T_RESP;
          endcase
        end
      end
      T_WRITE: state_d = T_RESP;
      T_READ:  state_d = T_RESP;
      T_START: state_d = T_SCAN;
      T_SCAN:  if (scan_done) state_d = T_RESP;
      T_RESP:  if (slot_free) state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  // memory port owner and handshake outputs
  always_comb begin
    mem_req       = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      T_INIT: begin
        // clearing pass over every cell
        mem_req.we    = 1'b1;
        mem_req.addr  = init_q;
        mem_req.wmask = '1;
      end
      T_IDLE: s_axis_tready = 1'b1;
      T_WRITE: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = {y_q, x_q};
        mem_req.wmask[CELL_OPAC] = 1'b1;
        mem_req.wdata[CELL_OPAC] = wall_q;
      end
      T_READ: begin
        mem_req.re   = 1'b1;
        mem_req.addr = {y_q, x_q};
      end
      T_START, T_SCAN: mem_req = scan_req;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_INIT;
      init_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == T_INIT) init_q <= init_q + ADDR_W'(1);
      if (state_q == T_RESP && slot_free) out_valid_q <= 1'b1;
      else if (m_axis_tready)             out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= s_axis_tuser;
      x_q    <= s_axis_tdata[COORD_W-1:0];
      y_q    <= s_axis_tdata[2*COORD_W-1:COORD_W];
      wall_q <= s_axis_tdata[2*COORD_W];
      rad_q  <= s_axis_tdata[2*COORD_W+RAD_W:2*COORD_W+1];
    end
    if (state_q == T_RESP && slot_free) begin
      out_op_q   <= op_q;
      // read data still held by the memory since the read cycle
      out_bits_q <= (sfov_op_e'(op_q) == OP_READ) ? mem_rdata : '0;
    end
  end

  assign scan_cmd.ox     = x_q;
  assign scan_cmd.oy     = y_q;
  assign scan_cmd.radius = rad_q;
  assign scan_cmd.w_eff  = clamp_map(width_q);
  assign scan_cmd.h_eff  = clamp_map(height_q);

  sfov_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (state_q == T_START),
    .cmd_i       (scan_cmd),
    .mem_rdata_i (mem_rdata),
    .mem_req_o   (scan_req),
    .done_o      (scan_done)
  );

  // one entry per cell: visible, explored, opacity
  sfov_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .re_i    (mem_req.re),
    .we_i    (mem_req.we),
    .addr_i  (mem_req.addr),
    .wmask_i (mem_req.wmask),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_op_q;
  assign m_axis_tdata  = {{(8-CELL_W){1'b0}}, out_bits_q};

endmodule
`default_nettype wire

### rtl/sfov_ram.sv
// generic single-port ram with bit write mask and registered read
`default_nettype none
module sfov_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     re_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wmask_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int b = 0; b < WIDTH; b++) begin
        if (wmask_i[b]) mem_q[addr_i][b] <= wdata_i[b];
      end
    end
    if (re_i) rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### rtl/sfov_scan.sv
// shadowcasting scan engine with frame stack
`default_nettype none
`include "assert_macros.svh"
module sfov_scan
  import sfov_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire sfov_cmd_t     cmd_i,
  input  wire logic [CELL_W-1:0] mem_rdata_i,
  output sfov_mem_req_t      mem_req_o,
  output logic               done_o
);

  sfov_scan_e state_q, state_d;
  sfov_cmd_t  cmd_q;
  logic [2*RAD_W-1:0]  rr_q;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic [2:0]          oct_q, oct_d;
  sfov_frame_t         cur_q, cur_d, cur_upd;
  logic [DEPTH_W-1:0]  depth_q, depth_d;
  sfov_frame_t         stack_q [STACK_DEPTH];
  logic                push_we;

  // latched cell under test
  logic [ROW_W-1:0]        c_adx_q;
  logic signed [NUM_W-1:0] c_ln_q, c_rn_q;
  logic [DEN_W-1:0]        c_ld_q, c_rd_q;
  logic                    c_onmap_q;
  logic [ADDR_W-1:0]       c_addr_q;

  // step datapath
  logic signed [DX_W-1:0]  dxn, negdx, dy, offx, offy;
  logic [ROW_W-1:0]        adx;
  logic signed [NUM_W-1:0] ln, rn;
  logic [DEN_W-1:0]        ld, rd;
  logic signed [POS_W-1:0] px, py;
  logic                    step_onmap, origin_on;
  logic                    less_start, less_end, step_pop, dx_neg, go_cell;
  logic [ADDR_W-1:0]       step_addr;
  logic [DEPTH_W-1:0]      dm1;

  // cell datapath
  logic [2*ROW_W-1:0]      sq_a, sq_b;
  logic [2*ROW_W:0]        dist_sq;
  logic                    wall, lit, push_ok;

  always_comb begin
    dxn    = cur_q.dx + DX_W'(1);
    negdx  = -dxn;
    adx    = negdx[ROW_W-1:0];
    ln     = $signed(NUM_W'({adx, 1'b1}));
    rn     = ln - NUM_W'(2);
    ld     = {cur_q.row, 1'b0} - DEN_W'(1);
    rd     = {cur_q.row, 1'b1};
    dy     = -$signed({2'b00, cur_q.row});
    offx   = unit_mul(OCT_M[oct_q][0], dxn) + unit_mul(OCT_M[oct_q][1], dy);
    offy   = unit_mul(OCT_M[oct_q][2], dxn) + unit_mul(OCT_M[oct_q][3], dy);
    px     = $signed(POS_W'({2'b00, cmd_q.ox})) + POS_W'(offx);
    py     = $signed(POS_W'({2'b00, cmd_q.oy})) + POS_W'(offy);
    step_onmap = !px[POS_W-1] && !py[POS_W-1]
              && ($unsigned(px) < POS_W'(cmd_q.w_eff))
              && ($unsigned(py) < POS_W'(cmd_q.h_eff));
    step_addr  = {py[COORD_W-1:0], px[COORD_W-1:0]};
    origin_on  = (MAP_W'(cmd_q.ox) < cmd_q.w_eff) && (MAP_W'(cmd_q.oy) < cmd_q.h_eff);
    less_start = slope_less(cur_q.sn, cur_q.sd, rn, rd);
    less_end   = slope_less(ln, ld, cur_q.en, cur_q.ed);
    dx_neg     = cur_q.dx[DX_W-1];
    step_pop   = (cur_q.row > ROW_W'(cmd_q.radius)) || (!dx_neg && cur_q.blocked);
    go_cell    = !step_pop && dx_neg && !less_start && !less_end;
    dm1        = depth_q - DEPTH_W'(1);

    sq_a = c_adx_q * c_adx_q;
    sq_b = cur_q.row * cur_q.row;
    dist_sq = {1'b0, sq_a} + {1'b0, sq_b};
    wall = !c_onmap_q || mem_rdata_i[CELL_OPAC];
    lit  = c_onmap_q && (dist_sq < (2*ROW_W+1)'(rr_q));
    push_ok = !slope_less(cur_q.sn, cur_q.sd, c_ln_q, c_ld_q)
           && (depth_q < DEPTH_W'(STACK_DEPTH - 1));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (start_i) state_d = S_CLEAR;
      S_CLEAR:  if (clr_q == '1) state_d = S_ORIGIN;
      S_ORIGIN: state_d = S_OCT;
      S_OCT:    state_d = S_STEP;
      S_STEP: begin
        priority if (step_pop && depth_q == '0) state_d = (oct_q == 3'd7) ? S_DONE : S_OCT;
        else if (go_cell)                        state_d = S_CELL;
        else                                     state_d = S_STEP;
      end
      S_CELL:   state_d = S_STEP;
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // frame and stack updates
  always_comb begin
    cur_d   = cur_q;
    depth_d = depth_q;
    oct_d   = oct_q;
    clr_d   = clr_q;
    push_we = 1'b0;
    cur_upd = cur_q;
    cur_upd.blocked = 1'b1;
    cur_upd.nn      = c_rn_q;
    cur_upd.nd      = c_rd_q;
    unique case (state_q)
      S_IDLE:   clr_d = '0;
      S_CLEAR:  clr_d = clr_q + ADDR_W'(1);
      S_ORIGIN: oct_d = '0;
      S_OCT: begin
        cur_d.row = ROW_W'(1);
        cur_d.dx  = -DX_W'(2);
        cur_d.sn  = NUM_W'(1);
        cur_d.sd  = DEN_W'(1);
        cur_d.en  = '0;
        cur_d.ed  = DEN_W'(1);
        cur_d.nn  = '0;
        cur_d.nd  = DEN_W'(1);
        cur_d.blocked = 1'b0;
      end
      S_STEP: begin
        priority if (step_pop) begin
          if (depth_q == '0) begin
            oct_d = oct_q + 3'd1;
          end else begin
            cur_d   = stack_q[dm1[STACK_IDX_W-1:0]];
            depth_d = dm1;
          end
        end else if (!dx_neg) begin
          cur_d.row = cur_q.row + ROW_W'(1);
          cur_d.dx  = -$signed({2'b00, cur_q.row}) - DX_W'(2);
        end else begin
          cur_d.dx = (!less_start && less_end) ? '0 : dxn;
        end
      end
      S_CELL: begin
        if (cur_q.blocked) begin
          if (wall) begin
            cur_d.nn = c_rn_q;
            cur_d.nd = c_rd_q;
          end else begin
            cur_d.blocked = 1'b0;
            cur_d.sn      = cur_q.nn;
            cur_d.sd      = cur_q.nd;
          end
        end else if (wall && (cur_q.row < ROW_W'(cmd_q.radius))) begin
          if (push_ok) begin
            push_we   = 1'b1;
            depth_d   = depth_q + DEPTH_W'(1);
            cur_d.row = cur_q.row + ROW_W'(1);
            cur_d.dx  = -$signed({2'b00, cur_q.row}) - DX_W'(2);
            cur_d.sn  = cur_q.sn;
            cur_d.sd  = cur_q.sd;
            cur_d.en  = c_ln_q;
            cur_d.ed  = c_ld_q;
            cur_d.nn  = '0;
            cur_d.nd  = DEN_W'(1);
            cur_d.blocked = 1'b0;
          end else begin
            cur_d = cur_upd;
          end
        end
      end
      S_DONE:  depth_d = '0;
      default: ;
    endcase
  end

  // memory requests and completion
  always_comb begin
    mem_req_o = '0;
    done_o    = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = clr_q;
        mem_req_o.wmask[CELL_VIS] = 1'b1;
      end
      S_ORIGIN: begin
        mem_req_o.we    = origin_on;
        mem_req_o.addr  = {cmd_q.oy, cmd_q.ox};
        mem_req_o.wmask[CELL_VIS] = 1'b1;
        mem_req_o.wmask[CELL_EXP] = 1'b1;
        mem_req_o.wdata = '1;
      end
      S_STEP: begin
        mem_req_o.re   = go_cell && step_onmap;
        mem_req_o.addr = step_addr;
      end
      S_CELL: begin
        mem_req_o.we    = lit;
        mem_req_o.addr  = c_addr_q;
        mem_req_o.wmask[CELL_VIS] = 1'b1;
        mem_req_o.wmask[CELL_EXP] = 1'b1;
        mem_req_o.wdata = '1;
      end
      S_DONE:  done_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      depth_q <= '0;
      oct_q   <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      oct_q   <= oct_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (state_q == S_IDLE && start_i) begin
      cmd_q <= cmd_i;
      rr_q  <= cmd_i.radius * cmd_i.radius;
    end
    if (state_q == S_STEP) begin
      c_adx_q   <= adx;
      c_ln_q    <= ln;
      c_rn_q    <= rn;
      c_ld_q    <= ld;
      c_rd_q    <= rd;
      c_onmap_q <= step_onmap;
      c_addr_q  <= step_addr;
    end
    if (push_we) stack_q[depth_q[STACK_IDX_W-1:0]] <= cur_upd;
  end

  `SFOV_ASSERT_IMP(a_no_rw_clash, mem_req_o.re, !mem_req_o.we, "scan reads and writes at once")
  `SFOV_ASSERT_IMP(a_done_empty, done_o, depth_q == '0, "frames left at end of scan")
  `SFOV_ASSERT_IMP(a_stack_bound, 1'b1, depth_q < DEPTH_W'(STACK_DEPTH), "frame stack overrun")
  `SFOV_ASSERT_NEXT(a_push_grows, push_we, depth_q == $past(depth_q) + DEPTH_W'(1),
                    "push did not grow the stack")

endmodule
`default_nettype wire
